[rtl/bitvector_edit_distance_search_assert.svh]
// Assertion macros for the bit-vector edit distance search checker.
`ifndef BITVECTOR_EDIT_DISTANCE_SEARCH_ASSERT_SVH
`define BITVECTOR_EDIT_DISTANCE_SEARCH_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define BEDS_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define BEDS_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/beds_pkg.sv]
// Shared constants, types and helpers of the bit-vector edit distance search.
package beds_pkg;

    localparam int PATTERN_BITS  = 63;
    localparam int ALPHABET_SIZE = 13;

    localparam int OP_W    = 2;
    localparam int SYM_W   = 4;
    localparam int DIST_W  = 6;
    localparam int SCORE_W = $clog2(PATTERN_BITS + 1);
    localparam int IDX_W   = (PATTERN_BITS > 1) ? $clog2(PATTERN_BITS) : 1;
    localparam int ADDR_W  = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;

    localparam int S_TDATA_W = ((OP_W + SYM_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((DIST_W + 7) / 8) * 8;
    localparam int DIST_MAX  = (1 << DIST_W) - 1;

    localparam logic [OP_W-1:0] OP_PATTERN = 2'd0;
    localparam logic [OP_W-1:0] OP_TEXT    = 2'd1;
    localparam logic [OP_W-1:0] OP_FINISH  = 2'd2;

    localparam logic [1:0] PHASE_IDLE = 2'd0;
    localparam logic [1:0] PHASE_LOAD = 2'd1;
    localparam logic [1:0] PHASE_SCAN = 2'd2;

    typedef logic [PATTERN_BITS-1:0] pvec_t;
    typedef logic [SCORE_W-1:0]      score_t;

    typedef struct packed {
        pvec_t vp;
        pvec_t vn;
    } vec_t;

    typedef struct packed {
        score_t last;
        score_t best;
    } scores_t;

    function automatic logic sym_in_range(input logic [SYM_W-1:0] sym);
        return 32'(sym) < 32'(ALPHABET_SIZE);
    endfunction

    function automatic logic [ADDR_W-1:0] sym_addr(input logic [SYM_W-1:0] sym);
        return ADDR_W'(sym);
    endfunction

    function automatic logic [DIST_W-1:0] sat_dist(input score_t d);
        if (32'(d) > 32'(DIST_MAX)) begin
            return '1;
        end
        return DIST_W'(d);
    endfunction

endpackage

[rtl/beds_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module beds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/beds_step.sv]
// One column step of the Myers bit-vector recurrence plus last-row score update.
module beds_step
    import beds_pkg::*;
(
    input  vec_t    cur,
    input  scores_t cur_scores,
    input  pvec_t   eq,
    input  score_t  m,
    output vec_t    nxt,
    output scores_t nxt_scores
);

    pvec_t            x;
    pvec_t            d0;
    pvec_t            hn;
    pvec_t            hp;
    pvec_t            xs;
    logic [IDX_W-1:0] top_idx;
    score_t           last_up;
    score_t           last_new;

    always_comb begin
        x       = eq | cur.vn;
        d0      = ((cur.vp + (x & cur.vp)) ^ cur.vp) | x;
        hn      = cur.vp & d0;
        hp      = cur.vn | ~(cur.vp | d0);
        xs      = hp << 1;
        nxt.vn  = xs & d0;
        nxt.vp  = (hn << 1) | ~(xs | d0);
        top_idx = IDX_W'(m - 1'b1);

        last_up = cur_scores.last;
        if (hp[top_idx] && (cur_scores.last < m)) begin
            last_up = cur_scores.last + 1'b1;
        end
        last_new = last_up;
        if (hn[top_idx] && (last_up != '0)) begin
            last_new = last_up - 1'b1;
        end
        nxt_scores.last = last_new;
        nxt_scores.best = (last_new < cur_scores.best) ? last_new : cur_scores.best;
    end

endmodule

[rtl/bitvector_edit_distance_search.sv]
// Top level of the bit-vector approximate match engine (masks in RAM, two stages).
//
//   channel | dir | tdata fields (low bit first)       | handshake
//   s_      | in  | op[1:0], symbol[5:2], zero pad     | s_tvalid / s_tready
//   m_      | out | distance[5:0], zero pad            | m_tvalid / m_tready
//
// One item per cycle while s_tready is high: stage 0 issues the match-mask RAM
// read, stage 1 does the read-modify-write of a mask or one 63-bit add and vector
// update on VP/VN. A finish result is written to the output register by stage 1.
// Reset clears phase, length and mask valid bits at once; no clearing pass.
// s_tready drops only while a finish waits in stage 1 and the output still holds
// an untaken result.
module bitvector_edit_distance_search
    import beds_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // op[1:0], symbol[5:2]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // distance[5:0]
);

    logic                     accept;
    logic [OP_W-1:0]          in_op;
    logic [SYM_W-1:0]         in_sym;

    logic                     s1_valid_reg, s1_valid_next;
    logic [OP_W-1:0]          s1_op_reg;
    logic [SYM_W-1:0]         s1_sym_reg;
    logic                     s1_fwd_hit_reg, s1_fwd_hit_next;
    pvec_t                    s1_fwd_data_reg;

    logic [1:0]               phase_reg, phase_next;
    score_t                   len_reg, len_next;
    vec_t                     vec_reg, vec_next;
    scores_t                  sc_reg, sc_next;
    logic [ALPHABET_SIZE-1:0] valid_reg, valid_next;

    logic                     m_tvalid_reg, m_tvalid_next;
    logic [DIST_W-1:0]        m_dist_reg, m_dist_next;

    logic                     s1_blocked;
    logic                     exec;
    logic                     s1_in_range;
    logic [ADDR_W-1:0]        s1_addr;
    pvec_t                    ram_rdata;
    pvec_t                    stored;
    pvec_t                    eq;
    logic                     new_pat;
    score_t                   len_base;

    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    pvec_t                    wr_data;

    vec_t                     step_cur;
    scores_t                  step_cur_sc;
    vec_t                     step_nxt;
    scores_t                  step_nxt_sc;

    assign in_op  = s_tdata[OP_W-1:0];
    assign in_sym = s_tdata[OP_W+SYM_W-1:OP_W];

    assign s_tready = !(s1_valid_reg && (s1_op_reg == OP_FINISH) && m_tvalid_reg);
    assign accept   = s_tvalid && s_tready;

    assign s1_blocked = (s1_op_reg == OP_FINISH) && m_tvalid_reg && !m_tready;
    assign exec       = s1_valid_reg && !s1_blocked;

    assign s1_in_range = sym_in_range(s1_sym_reg);
    assign s1_addr     = sym_addr(s1_sym_reg);

    beds_ram #(
        .WIDTH (PATTERN_BITS),
        .DEPTH (ALPHABET_SIZE)
    ) u_mask_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (accept && sym_in_range(in_sym)),
        .raddr (sym_addr(in_sym)),
        .rdata (ram_rdata)
    );

    always_comb begin
        if (s1_fwd_hit_reg) begin
            stored = s1_fwd_data_reg;
        end else if (s1_in_range && valid_reg[s1_addr]) begin
            stored = ram_rdata;
        end else begin
            stored = '0;
        end
        eq = s1_in_range ? stored : '0;
    end

    always_comb begin
        if (phase_reg == PHASE_SCAN) begin
            step_cur    = vec_reg;
            step_cur_sc = sc_reg;
        end else begin
            step_cur.vp      = ~({PATTERN_BITS{1'b1}} << len_reg);
            step_cur.vn      = '0;
            step_cur_sc.last = len_reg;
            step_cur_sc.best = len_reg;
        end
    end

    beds_step u_step (
        .cur        (step_cur),
        .cur_scores (step_cur_sc),
        .eq         (eq),
        .m          (len_reg),
        .nxt        (step_nxt),
        .nxt_scores (step_nxt_sc)
    );

    always_comb begin
        phase_next    = phase_reg;
        len_next      = len_reg;
        vec_next      = vec_reg;
        sc_next       = sc_reg;
        valid_next    = valid_reg;
        wr_en         = 1'b0;
        wr_addr       = s1_addr;
        new_pat       = (phase_reg == PHASE_IDLE);
        len_base      = new_pat ? '0 : len_reg;
        wr_data       = (new_pat ? '0 : eq) | (pvec_t'(1) << len_base);
        m_dist_next   = m_dist_reg;
        m_tvalid_next = m_tready ? 1'b0 : m_tvalid_reg;

        if (exec) begin
            case (s1_op_reg)
                OP_PATTERN: begin
                    if (phase_reg != PHASE_SCAN) begin
                        if (new_pat) begin
                            valid_next = '0;
                        end
                        phase_next = PHASE_LOAD;
                        len_next   = len_base;
                        if (32'(len_base) < PATTERN_BITS) begin
                            len_next = len_base + 1'b1;
                            if (s1_in_range) begin
                                wr_en               = 1'b1;
                                valid_next[s1_addr] = 1'b1;
                            end
                        end
                    end
                end
                OP_TEXT: begin
                    phase_next = PHASE_SCAN;
                    if (len_reg == '0) begin
                        vec_next = step_cur;
                        sc_next  = step_cur_sc;
                    end else begin
                        vec_next = step_nxt;
                        sc_next  = step_nxt_sc;
                    end
                end
                OP_FINISH: begin
                    m_dist_next   = sat_dist((phase_reg == PHASE_SCAN) ? sc_reg.best : len_reg);
                    m_tvalid_next = 1'b1;
                    phase_next    = PHASE_IDLE;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        s1_valid_next   = accept ? 1'b1 : (exec ? 1'b0 : s1_valid_reg);
        s1_fwd_hit_next = wr_en && sym_in_range(in_sym) && (wr_addr == sym_addr(in_sym));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            phase_reg    <= PHASE_IDLE;
            len_reg      <= '0;
            vec_reg      <= '0;
            sc_reg       <= '0;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            phase_reg    <= phase_next;
            len_reg      <= len_next;
            vec_reg      <= vec_next;
            sc_reg       <= sc_next;
            valid_reg    <= valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_op_reg       <= in_op;
            s1_sym_reg      <= in_sym;
            s1_fwd_hit_reg  <= s1_fwd_hit_next;
            s1_fwd_data_reg <= wr_data;
        end
        m_dist_reg <= m_dist_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(m_dist_reg);

endmodule

[rtl/beds_checker.sv]
// Port-level checker for the bit-vector edit distance search, bound to the top.
`include "bitvector_edit_distance_search_assert.svh"

module beds_checker
    import beds_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic fin_xfer;

    assign fin_xfer = s_tvalid && s_tready && (s_tdata[OP_W-1:0] == OP_FINISH);

    `BEDS_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `BEDS_ASSERT_IMP(a_out_cause, aclk, aresetn, $rose(m_tvalid), $past(fin_xfer, 2), "result without a finish transfer")
    `BEDS_ASSERT_IMP(a_stall_cause, aclk, aresetn, !s_tready, m_tvalid && (m_tdata[M_TDATA_W-1:DIST_W] == '0), "input stalled with no pending result")

endmodule

bind bitvector_edit_distance_search beds_checker u_beds_checker (.*);

[tb/tb_bitvector_edit_distance_search.sv]
// Self-checking testbench for the bit-vector edit distance search block.
module tb_bitvector_edit_distance_search;
    import beds_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [OP_W-1:0] OP_NONE = 2'd3;
    localparam int ITEM_TARGET = 1700;
    localparam int CALM_FROM   = 400;
    localparam int CALM_TO     = 800;
    localparam int HOLD_AT     = 1200;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 20;

    class distance_scoreboard;
        logic [63:0]      masks [ALPHABET_SIZE];
        int unsigned      pat_len;
        logic [63:0]      plus_vec;
        logic [63:0]      minus_vec;
        int unsigned      row_score;
        int unsigned      best;
        logic [1:0]       phase;
        logic [DIST_W-1:0] distance_q[$];
        int               errors;

        function new();
            foreach (masks[i]) masks[i] = '0;
            pat_len   = 0;
            plus_vec  = '0;
            minus_vec = '0;
            row_score = 0;
            best      = 0;
            phase     = PHASE_IDLE;
            errors    = 0;
        endfunction

        function void advance_column(logic [SYM_W-1:0] sym);
            logic [63:0] eq, x, d0, hn, hp, top;
            if (pat_len == 0) return;
            eq = (sym < ALPHABET_SIZE) ? masks[sym] : '0;
            x = eq | minus_vec;
            d0 = ((plus_vec + (x & plus_vec)) ^ plus_vec) | x;
            hn = plus_vec & d0;
            hp = minus_vec | ~(plus_vec | d0);
            x = hp << 1;
            minus_vec = x & d0;
            plus_vec = (hn << 1) | ~(x | d0);
            top = 64'd1 << (pat_len - 1);
            if ((hp & top) != 0 && row_score < pat_len) row_score++;
            if ((hn & top) != 0 && row_score > 0) row_score--;
            if (row_score < best) best = row_score;
        endfunction

        function void note_input(logic [OP_W-1:0] op, logic [SYM_W-1:0] sym);
            int unsigned d;
            case (op)
                OP_PATTERN: begin
                    if (phase != PHASE_SCAN) begin
                        if (phase == PHASE_IDLE) begin
                            foreach (masks[i]) masks[i] = '0;
                            pat_len = 0;
                            phase = PHASE_LOAD;
                        end
                        if (pat_len < PATTERN_BITS) begin
                            if (sym < ALPHABET_SIZE) masks[sym][pat_len] = 1'b1;
                            pat_len++;
                        end
                    end
                end
                OP_TEXT: begin
                    if (phase != PHASE_SCAN) begin
                        plus_vec  = (64'd1 << pat_len) - 64'd1;
                        minus_vec = '0;
                        row_score = pat_len;
                        best      = pat_len;
                        phase     = PHASE_SCAN;
                    end
                    advance_column(sym);
                end
                OP_FINISH: begin
                    d = (phase == PHASE_SCAN) ? best : pat_len;
                    if (d > DIST_MAX) d = DIST_MAX;
                    distance_q.push_back(DIST_W'(d));
                    phase = PHASE_IDLE;
                end
                default: ;
            endcase
        endfunction

        function void check_distance(logic [DIST_W-1:0] got);
            logic [DIST_W-1:0] want;
            if (distance_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got %0d", $time, got);
                return;
            end
            want = distance_q.pop_front();
            if (got !== want) begin
                errors++;
                $display("%0t: distance mismatch, expected %0d, got %0d", $time, want, got);
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    int                   cyc = 0;
    int                   hold_left = 0;
    int                   items_sent = 0;
    distance_scoreboard   sb = new();

    bitvector_edit_distance_search dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cyc <= cyc + 1;
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            sb.note_input(s_tdata[1:0], s_tdata[5:2]);
        end
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_distance(m_tdata[DIST_W-1:0]);
        end
    end

    // receiver: random backpressure, one long hold-off to fill the pipeline
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (cyc == HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= (cyc >= CALM_FROM && cyc < CALM_TO) || ($urandom_range(99) >= 32);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    task automatic send_item(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym);
        while (!(cyc >= CALM_FROM && cyc < CALM_TO) && $urandom_range(99) < 32) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, sym, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    function automatic logic [SYM_W-1:0] pick_symbol(input int alpha);
        if ($urandom_range(99) < 6) return SYM_W'($urandom_range(15, ALPHABET_SIZE));
        return SYM_W'($urandom_range(alpha - 1, 0));
    endfunction

    // one query: pattern (or the retained one), text with some noise, finish
    task automatic run_query();
        int alpha, plen, tlen, roll;
        roll  = $urandom_range(99);
        alpha = ($urandom_range(3) == 0) ? ALPHABET_SIZE : $urandom_range(4, 2);
        if (roll < 6) begin
            plen = $urandom_range(70, 58);
            tlen = $urandom_range(1) ? 0 : $urandom_range(40, 1);
        end else if (roll < 14) begin
            plen = 0;
            tlen = $urandom_range(12);
        end else begin
            plen = $urandom_range(12, 1);
            tlen = $urandom_range(24);
        end
        for (int i = 0; i < plen; i++) begin
            send_item(OP_PATTERN, pick_symbol(alpha));
            if ($urandom_range(99) < 2) send_item(OP_NONE, SYM_W'($urandom));
        end
        for (int i = 0; i < tlen; i++) begin
            send_item(OP_TEXT, pick_symbol(alpha));
            if ($urandom_range(99) < 4) begin
                send_item($urandom_range(1) ? OP_PATTERN : OP_NONE, SYM_W'($urandom));
            end
        end
        send_item(OP_FINISH, SYM_W'($urandom));
        items_sent += plen + tlen + 1;
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty pattern, with and without text
        send_item(OP_FINISH, 4'd0);
        send_item(OP_TEXT, 4'd5);
        send_item(OP_FINISH, 4'd15);
        // pattern with out-of-alphabet codes, finish without text
        send_item(OP_PATTERN, 4'd0);
        send_item(OP_PATTERN, 4'd12);
        send_item(OP_PATTERN, 4'd15);
        send_item(OP_PATTERN, 4'd13);
        send_item(OP_FINISH, 4'd0);
        // search the retained pattern, out-of-alphabet text
        send_item(OP_TEXT, 4'd0);
        send_item(OP_TEXT, 4'd12);
        send_item(OP_TEXT, 4'd14);
        send_item(OP_TEXT, 4'd15);
        send_item(OP_FINISH, 4'd0);
        // pattern symbol during scan and op 3 are dropped
        send_item(OP_PATTERN, 4'd1);
        send_item(OP_PATTERN, 4'd2);
        send_item(OP_TEXT, 4'd1);
        send_item(OP_PATTERN, 4'd7);
        send_item(OP_NONE, 4'd10);
        send_item(OP_TEXT, 4'd2);
        send_item(OP_FINISH, 4'd0);
        send_item(OP_TEXT, 4'd1);
        send_item(OP_TEXT, 4'd2);
        send_item(OP_FINISH, 4'd0);

        while (items_sent < ITEM_TARGET) run_query();
        s_tvalid <= 1'b0;
        // let the monitor note the last transfer before looking at the queue
        @(posedge aclk);

        while (sb.distance_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.errors == 0 && sb.distance_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
